/* hdl/utf8s_pkg.sv */
// Shared types and constants of the UTF-8 sanitizer.
package utf8s_pkg;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [20:0] CP_MAX  = 21'h10FFFF;
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [20:0] MIN_2B  = 21'h000080;
	localparam logic [20:0] MIN_3B  = 21'h000800;
	localparam logic [20:0] MIN_4B  = 21'h010000;

	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_2B   = 3'd2;
	localparam logic [2:0] SEQ_3B   = 3'd3;
	localparam logic [2:0] SEQ_4B   = 3'd4;

	localparam logic [1:0] PH_LAST = 2'd2;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_PW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// One command: rep replacement characters, then pass bytes taken from bytes.
	typedef struct packed {
		logic [2:0]      rep;
		logic [2:0]      pass;
		logic [3:0][7:0] bytes;
		logic            last;
	} cmd_t;

endpackage

/* hdl/utf8s_front.sv */
// Front end: decodes each input byte against the open sequence and issues commands.
module utf8s_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             last_byte,
	output logic             cmd_push,
	output utf8s_pkg::cmd_t  cmd
);
	import utf8s_pkg::*;

	logic        nul_q, nul_d;
	logic [2:0]  seq_q, seq_d;
	logic [1:0]  held_q, held_d;
	logic [20:0] part_q, part_d;
	logic [7:0]  hb_q [3];
	logic        hb_we;
	logic [1:0]  hb_idx;
	logic [20:0] cp;
	logic [20:0] cp_min;
	logic        ok;
	logic        do_lead;

	always_comb begin
		cmd     = '0;
		nul_d   = nul_q;
		seq_d   = seq_q;
		held_d  = held_q;
		part_d  = part_q;
		hb_we   = 1'b0;
		hb_idx  = held_q;
		do_lead = 1'b0;
		cp      = {part_q[14:0], in_byte[5:0]};
		case (seq_q)
			SEQ_2B:  cp_min = MIN_2B;
			SEQ_3B:  cp_min = MIN_3B;
			default: cp_min = MIN_4B;
		endcase
		ok = (cp >= cp_min) && (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI));
		if (!nul_q) begin
			if (seq_q != SEQ_NONE) begin
				if (in_byte[7:6] == 2'b10) begin
					if (({1'b0, held_q} + 3'd1) >= seq_q) begin
						if (ok) begin
							cmd.pass     = {1'b0, held_q} + 3'd1;
							cmd.bytes[0] = hb_q[0];
							cmd.bytes[1] = hb_q[1];
							cmd.bytes[2] = hb_q[2];
							cmd.bytes[held_q] = in_byte;
						end else begin
							cmd.rep = seq_q;
						end
						seq_d  = SEQ_NONE;
						held_d = 2'd0;
						part_d = '0;
					end else begin
						hb_we  = 1'b1;
						held_d = held_q + 2'd1;
						part_d = cp;
					end
				end else begin
					cmd.rep = {1'b0, held_q};
					seq_d   = SEQ_NONE;
					held_d  = 2'd0;
					part_d  = '0;
					do_lead = 1'b1;
				end
			end else begin
				do_lead = 1'b1;
			end
			if (do_lead) begin
				if (in_byte == 8'h00) begin
					nul_d = 1'b1;
				end else if (in_byte inside {[8'h01:8'h7F]}) begin
					cmd.pass     = 3'd1;
					cmd.bytes[0] = in_byte;
				end else if (in_byte inside {[8'hC0:8'hDF]}) begin
					seq_d  = SEQ_2B;
					part_d = {16'd0, in_byte[4:0]};
				end else if (in_byte inside {[8'hE0:8'hEF]}) begin
					seq_d  = SEQ_3B;
					part_d = {17'd0, in_byte[3:0]};
				end else if (in_byte inside {[8'hF0:8'hF7]}) begin
					seq_d  = SEQ_4B;
					part_d = {18'd0, in_byte[2:0]};
				end else begin
					cmd.rep = cmd.rep + 3'd1;
				end
				if (seq_d != SEQ_NONE) begin
					hb_we  = 1'b1;
					hb_idx = 2'd0;
					held_d = 2'd1;
				end
			end
			if (last_byte && (seq_d != SEQ_NONE)) begin
				cmd.rep = cmd.rep + {1'b0, held_d};
			end
		end
		cmd.last = last_byte;
		if (last_byte) begin
			nul_d  = 1'b0;
			seq_d  = SEQ_NONE;
			held_d = 2'd0;
			part_d = '0;
		end
		cmd_push = accept && ((cmd.rep != 3'd0) || (cmd.pass != 3'd0) || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_q  <= 1'b0;
			seq_q  <= SEQ_NONE;
			held_q <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			nul_q  <= nul_d;
			seq_q  <= seq_d;
			held_q <= held_d;
			part_q <= part_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hb_we) begin
			hb_q[hb_idx] <= in_byte;
		end
	end

endmodule

/* hdl/utf8s_cmdq.sv */
// Short command queue between the front end and the back end.
module utf8s_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  utf8s_pkg::cmd_t  wr_cmd,
	output logic             full,
	input  logic             rd_en,
	output logic             avail,
	output utf8s_pkg::cmd_t  rd_cmd
);
	import utf8s_pkg::*;

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_PW-1:0] wp_q, rp_q;
	logic [CQ_CW-1:0] cnt_q;
	logic             do_wr, do_rd;

	function automatic logic [CQ_PW-1:0] ptr_next(input logic [CQ_PW-1:0] p);
		if (p == CQ_PW'(CQ_DEPTH - 1)) begin
			return '0;
		end
		return p + CQ_PW'(1);
	endfunction

	assign full   = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign avail  = (cnt_q != '0);
	assign rd_cmd = mem_q[rp_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= ptr_next(wp_q);
			end
			if (do_rd) begin
				rp_q <= ptr_next(rp_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

endmodule

/* hdl/utf8s_back.sv */
// Back end: expands commands into output bytes and holds the output register.
module utf8s_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_avail,
	input  utf8s_pkg::cmd_t  q_cmd,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             run_last,
	output logic             string_end
);
	import utf8s_pkg::*;

	logic            busy_q;
	logic [2:0]      rep_q;
	logic [1:0]      ph_q;
	logic [2:0]      pass_q;
	logic [2:0]      pidx_q;
	logic [3:0][7:0] bytes_q;
	logic            last_q;

	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic            obv_q, orl_q, ose_q;

	logic            slot_free, emit, take, fin, bv;
	logic [7:0]      ob;

	always_comb begin
		ob  = 8'h00;
		bv  = 1'b1;
		fin = 1'b0;
		if (rep_q != 3'd0) begin
			case (ph_q)
				2'd0:    ob = REPL_B0;
				2'd1:    ob = REPL_B1;
				default: ob = REPL_B2;
			endcase
			fin = (rep_q == 3'd1) && (ph_q == PH_LAST) && (pass_q == 3'd0);
		end else if (pass_q != 3'd0) begin
			ob  = bytes_q[pidx_q[1:0]];
			fin = ((pidx_q + 3'd1) == pass_q);
		end else begin
			bv  = 1'b0;
			fin = 1'b1;
		end
	end

	assign slot_free = !ovalid_q || pop;
	assign emit      = busy_q && slot_free;
	assign take      = (!busy_q || (emit && fin)) && q_avail;
	assign q_pop     = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rep_q    <= 3'd0;
			ph_q     <= 2'd0;
			pass_q   <= 3'd0;
			pidx_q   <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				rep_q  <= q_cmd.rep;
				ph_q   <= 2'd0;
				pass_q <= q_cmd.pass;
				pidx_q <= 3'd0;
			end else if (emit) begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				if (rep_q != 3'd0) begin
					if (ph_q == PH_LAST) begin
						ph_q  <= 2'd0;
						rep_q <= rep_q - 3'd1;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end else if (pass_q != 3'd0) begin
					pidx_q <= pidx_q + 3'd1;
				end
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bytes_q <= q_cmd.bytes;
			last_q  <= q_cmd.last;
		end
		if (emit) begin
			obyte_q <= ob;
			obv_q   <= bv;
			orl_q   <= fin;
			ose_q   <= fin && last_q;
		end
	end

	assign empty      = !ovalid_q;
	assign out_byte   = obyte_q;
	assign byte_valid = obv_q;
	assign run_last   = orl_q;
	assign string_end = ose_q;

endmodule

/* hdl/utf8_sanitizer.sv */
// Top level of the streaming UTF-8 sanitizer.
//
// Input channel: a raw byte with last_byte is a transaction when push is high
// and full is low. Output channel: while empty is low the oldest result byte is
// on out_byte, byte_valid, run_last and string_end, and pop takes it.
// ASCII passes through, a complete well-formed sequence is released in one go,
// and every byte of a bad, overlong, surrogate, out-of-range or cut-off sequence
// is replaced by EF BF BD. A NUL mutes the rest of the string. The last byte
// closes the string; when it gives no data a single empty result marks the end.
// The front end takes one byte per cycle while full is low and writes commands
// into a two-entry queue; the back end drains a command at one result byte per
// cycle while its output register is free; an item gives up to 12 results and
// an item without results puts nothing into the queue. With the back end idle, a
// result passes the queue and the command registers into the output register.
// When the receiver stalls the result holds, the queue fills and full rises.
// Reset empties the queue and the output register and closes any open string.
module utf8_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end
);
	import utf8s_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic cmd_push, q_full, q_avail, q_pop;

	assign full = q_full;

	utf8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !q_full),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	utf8s_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (q_full),
		.rd_en  (q_pop),
		.avail  (q_avail),
		.rd_cmd (cmd_out)
	);

	utf8s_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_cmd      (cmd_out),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

/* hdl/utf8s_checker.sv */
// Port-level checker for the UTF-8 sanitizer and its bind statement.
module utf8s_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       string_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_valid)
			&& $stable(run_last) && $stable(string_end)))
		else $error("waiting result changed while stalled");

	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_end) |-> run_last)
		else $error("string end without end of run");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (string_end && out_byte == 8'h00))
		else $error("empty result that does not close the string");

	a_repl_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && byte_valid && out_byte == 8'hEF && !run_last)
			##1 (!empty && byte_valid && out_byte == 8'hBF)
			|-> !string_end)
		else $error("string closed in the middle of a replacement");

endmodule

bind utf8_sanitizer utf8s_checker u_chk (.*);
